// File: rtl/assert_macros.svh
// Assertion macros used by the connection table engine core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/tcte_pkg.sv
// Types and constants of the connection table engine.
`timescale 1ns / 1ps
`default_nettype none
package tcte_pkg;

    localparam logic [1:0] ACT_SYNACK = 2'd0;
    localparam logic [1:0] ACT_RESET  = 2'd1;
    localparam logic [1:0] ACT_DATA   = 2'd2;
    localparam logic [1:0] ACT_RETX   = 2'd3;

    localparam logic [1:0] CS_CLOSED  = 2'd0;
    localparam logic [1:0] CS_SYNRCVD = 2'd1;
    localparam logic [1:0] CS_ESTAB   = 2'd2;

    localparam logic [2:0] CFG_RTO_INITIAL   = 3'd0;
    localparam logic [2:0] CFG_MAX_RETRY     = 3'd1;
    localparam logic [2:0] CFG_INIT_CWND     = 3'd2;
    localparam logic [2:0] CFG_INIT_SSTHRESH = 3'd3;
    localparam logic [2:0] CFG_INITIAL_SEQ   = 3'd4;

    localparam logic [15:0] RTO_MAX = 16'd65535;

    typedef struct packed {
        logic [31:0] local_addr;
        logic [31:0] remote_addr;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [31:0] send_seq;
        logic [31:0] recv_ack;
        logic [31:0] last_tick;
        logic [7:0]  retry;
        logic [15:0] rto;
        logic [15:0] cwnd;
        logic [15:0] ssthresh;
    } t_entry;

    typedef struct packed {
        logic [31:0] remote_addr;
        logic [31:0] local_addr;
        logic [15:0] remote_port;
        logic [15:0] local_port;
        logic        syn_bit;
        logic        ack_bit;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [15:0] data_len;
    } t_seg;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  entry_index;
        logic [31:0] local_addr;
        logic [31:0] remote_addr;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [31:0] seq;
        logic [31:0] ack;
        logic        syn;
        logic [15:0] deliver_len;
        logic        last;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RD    = 4'b0010,
        S_CMP   = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

endpackage
`default_nettype wire

// File: rtl/tcp_connection_table_engine_core.sv
// Top level of the passive-open TCP connection table engine.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Passive-open TCP connection table. Each word on the slave stream is either a
// segment (tuser 0) or a timer tick (tuser 1). A segment walks the table
// entry by entry (read issue in S_RD, then compare in S_CMP against the
// registered read data of the entry memory) until the first open entry with
// the same port pair, or to the end, visiting at most NUM_CONNS entries; the
// entry is updated in that last compare state. S_FLUSH then hands the result
// to the output register, waiting while the master side stalls, and S_IDLE
// takes the next word. A tick walks all entries and may also wait while the
// master side stalls. Results of a tick are held one behind so the final
// one leaves with tlast set; at most eight retransmits leave per tick. The
// table starts empty after reset; no clearing pass is needed since the
// contents of a closed entry are never used. Config writes go through a
// separate valid/ready channel and are taken at once; write them only while
// the engine is idle.
module tcp_connection_table_engine_core #(
    parameter int NUM_CONNS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config write channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [2:0]   i_cfg_addr,
    input  wire [31:0]  i_cfg_data,
    // slave stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // remote_addr, local_addr, remote_port, local_port, syn_bit, ack_bit,
    // seq_num, ack_num, data_len, zero pad
    input  wire [183:0] s_axis_tdata,
    // operation
    input  wire [0:0]   s_axis_tuser,
    // master stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // entry_index, out_local_addr, out_remote_addr, out_local_port,
    // out_remote_port, out_seq, out_ack, out_syn, deliver_len, zero pad
    output logic [183:0] m_axis_tdata,
    // action
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    localparam int AW = (NUM_CONNS > 1) ? $clog2(NUM_CONNS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_CONNS - 1);

    // config registers
    logic [15:0] r_rto_initial;
    logic [7:0]  r_max_retry;
    logic [15:0] r_init_cwnd;
    logic [15:0] r_init_ssthresh;
    logic [31:0] r_initial_seq;

    tcte_pkg::t_state  r_state, n_state;
    logic              r_op;
    tcte_pkg::t_seg    r_in;
    logic [31:0]       r_now;
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_free_found, n_free_found;
    logic [AW-1:0]     r_free_idx, n_free_idx;
    logic [3:0]        r_nres, n_nres;
    logic [1:0]        r_cst [NUM_CONNS];

    tcte_pkg::t_result r_pend, n_pend;
    logic              r_pend_valid, n_pend_valid;
    tcte_pkg::t_result r_out, n_out;
    logic              r_out_valid, n_out_valid;

    // memory ports
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    tcte_pkg::t_entry  mem_wdata;
    tcte_pkg::t_entry  rdata;

    // conn state write
    logic              cst_we;
    logic [AW-1:0]     cst_addr;
    logic [1:0]        cst_val;

    logic              in_acc;
    logic              out_free;
    logic              out_load;
    tcte_pkg::t_result out_load_data;

    tcte_ram #(.DEPTH(NUM_CONNS), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == tcte_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.action;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {4'd0, r_out.deliver_len, r_out.syn, r_out.ack, r_out.seq,
                            r_out.remote_port, r_out.local_port, r_out.remote_addr,
                            r_out.local_addr, r_out.entry_index};

    // Config writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rto_initial   <= 16'd3;
            r_max_retry     <= 8'd5;
            r_init_cwnd     <= 16'd1;
            r_init_ssthresh <= 16'd64;
            r_initial_seq   <= 32'd1000;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                tcte_pkg::CFG_RTO_INITIAL:   r_rto_initial   <= i_cfg_data[15:0];
                tcte_pkg::CFG_MAX_RETRY:     r_max_retry     <= i_cfg_data[7:0];
                tcte_pkg::CFG_INIT_CWND:     r_init_cwnd     <= i_cfg_data[15:0];
                tcte_pkg::CFG_INIT_SSTHRESH: r_init_ssthresh <= i_cfg_data[15:0];
                tcte_pkg::CFG_INITIAL_SEQ:   r_initial_seq   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Main sequencer: scan, update, emit.
    always_comb begin
        logic        open_i;
        logic        match;
        logic        free_any;
        logic [AW-1:0] free_idx;
        logic [31:0] elapsed;
        logic        due;
        logic        advance;
        tcte_pkg::t_result res;
        logic        emit;

        n_state      = r_state;
        n_idx        = r_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_nres       = r_nres;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wdata    = rdata;
        cst_we       = 1'b0;
        cst_addr     = r_idx;
        cst_val      = tcte_pkg::CS_CLOSED;
        out_load      = 1'b0;
        out_load_data = r_pend;
        advance      = 1'b0;
        emit         = 1'b0;
        res          = '0;

        open_i   = (r_cst[r_idx] == tcte_pkg::CS_SYNRCVD) ||
                   (r_cst[r_idx] == tcte_pkg::CS_ESTAB);
        match    = open_i && (rdata.local_port == r_in.local_port) &&
                   (rdata.remote_port == r_in.remote_port);
        free_any = r_free_found || !open_i;
        free_idx = r_free_found ? r_free_idx : r_idx;
        elapsed  = r_now - rdata.last_tick;
        due      = elapsed >= {16'd0, rdata.rto};

        case (r_state)
            tcte_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state      = tcte_pkg::S_RD;
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_nres       = '0;
                end
            end
            tcte_pkg::S_RD: begin
                n_state = tcte_pkg::S_CMP;
            end
            tcte_pkg::S_CMP: begin
                if (!r_op) begin
                    if (!open_i && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_idx;
                    end
                    if (match || r_idx == LAST_IDX) begin
                        n_state = tcte_pkg::S_FLUSH;
                        // reset answer by default
                        res.action      = tcte_pkg::ACT_RESET;
                        res.local_addr  = r_in.local_addr;
                        res.remote_addr = r_in.remote_addr;
                        res.local_port  = r_in.local_port;
                        res.remote_port = r_in.remote_port;
                        res.seq         = r_in.ack_bit ? r_in.ack_num : 32'd0;
                        res.ack         = r_in.seq_num + {16'd0, r_in.data_len};
                        if (r_in.syn_bit) begin
                            if (!match) begin
                                emit = 1'b1;
                                if (free_any) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = free_idx;
                                    mem_wdata.local_addr  = r_in.local_addr;
                                    mem_wdata.remote_addr = r_in.remote_addr;
                                    mem_wdata.local_port  = r_in.local_port;
                                    mem_wdata.remote_port = r_in.remote_port;
                                    mem_wdata.recv_ack    = r_in.seq_num + 32'd1;
                                    mem_wdata.send_seq    = r_initial_seq;
                                    mem_wdata.last_tick   = r_now;
                                    mem_wdata.retry       = '0;
                                    mem_wdata.rto         = r_rto_initial;
                                    mem_wdata.cwnd        = r_init_cwnd;
                                    mem_wdata.ssthresh    = r_init_ssthresh;
                                    cst_we   = 1'b1;
                                    cst_addr = free_idx;
                                    cst_val  = tcte_pkg::CS_SYNRCVD;
                                    res.action      = tcte_pkg::ACT_SYNACK;
                                    res.entry_index = 3'(free_idx);
                                    res.seq         = r_initial_seq;
                                    res.ack         = r_in.seq_num + 32'd1;
                                    res.syn         = 1'b1;
                                end
                            end
                        end else if (match) begin
                            if (r_cst[r_idx] == tcte_pkg::CS_SYNRCVD && r_in.ack_bit) begin
                                if (r_in.ack_num == rdata.send_seq + 32'd1) begin
                                    mem_we = 1'b1;
                                    mem_wdata.send_seq  = r_in.ack_num;
                                    mem_wdata.last_tick = r_now;
                                    mem_wdata.retry     = '0;
                                    mem_wdata.rto       = r_rto_initial;
                                    cst_we  = 1'b1;
                                    cst_val = tcte_pkg::CS_ESTAB;
                                end
                            end else if (r_cst[r_idx] == tcte_pkg::CS_ESTAB &&
                                         r_in.data_len != 16'd0) begin
                                mem_we = 1'b1;
                                mem_wdata.recv_ack  = rdata.recv_ack + {16'd0, r_in.data_len};
                                mem_wdata.cwnd      = (rdata.cwnd < rdata.ssthresh) ?
                                                      rdata.cwnd + 16'd1 : rdata.cwnd;
                                mem_wdata.last_tick = r_now;
                                mem_wdata.retry     = '0;
                                mem_wdata.rto       = r_rto_initial;
                                emit = 1'b1;
                                res.action      = tcte_pkg::ACT_DATA;
                                res.entry_index = 3'(r_idx);
                                res.local_addr  = rdata.local_addr;
                                res.remote_addr = rdata.remote_addr;
                                res.local_port  = rdata.local_port;
                                res.remote_port = rdata.remote_port;
                                res.seq         = rdata.send_seq;
                                res.ack         = mem_wdata.recv_ack;
                                res.deliver_len = r_in.data_len;
                            end
                        end else begin
                            emit = 1'b1;
                        end
                        // pend is empty during a segment
                        if (emit) begin
                            n_pend       = res;
                            n_pend_valid = 1'b1;
                        end
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = tcte_pkg::S_RD;
                    end
                end else begin
                    advance = 1'b1;
                    if (open_i && due) begin
                        if (rdata.retry >= r_max_retry) begin
                            cst_we = 1'b1;
                        end else if (r_nres < 4'd8) begin
                            if (!r_pend_valid || out_free) begin
                                mem_we = 1'b1;
                                mem_wdata.ssthresh  = (rdata.cwnd > 16'd1) ?
                                                      (rdata.cwnd >> 1) : 16'd2;
                                mem_wdata.cwnd      = 16'd1;
                                mem_wdata.last_tick = r_now;
                                mem_wdata.retry     = rdata.retry + 8'd1;
                                mem_wdata.rto       = rdata.rto[15] ? tcte_pkg::RTO_MAX :
                                                      {rdata.rto[14:0], 1'b0};
                                res.action      = tcte_pkg::ACT_RETX;
                                res.entry_index = 3'(r_idx);
                                res.local_addr  = rdata.local_addr;
                                res.remote_addr = rdata.remote_addr;
                                res.local_port  = rdata.local_port;
                                res.remote_port = rdata.remote_port;
                                res.seq         = rdata.send_seq;
                                res.ack         = rdata.recv_ack;
                                res.syn         = (r_cst[r_idx] == tcte_pkg::CS_SYNRCVD);
                                // push the held result out, hold the new one
                                if (r_pend_valid) begin
                                    out_load      = 1'b1;
                                    out_load_data = r_pend;
                                end
                                n_pend       = res;
                                n_pend_valid = 1'b1;
                                n_nres       = r_nres + 4'd1;
                            end else begin
                                advance = 1'b0;
                            end
                        end
                    end
                    if (advance) begin
                        if (r_idx == LAST_IDX) begin
                            n_state = tcte_pkg::S_FLUSH;
                        end else begin
                            n_idx   = r_idx + AW'(1);
                            n_state = tcte_pkg::S_RD;
                        end
                    end
                end
            end
            tcte_pkg::S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = tcte_pkg::S_IDLE;
                end else if (out_free) begin
                    out_load           = 1'b1;
                    out_load_data      = r_pend;
                    out_load_data.last = 1'b1;
                    n_pend_valid       = 1'b0;
                    n_state            = tcte_pkg::S_IDLE;
                end
            end
            default: n_state = tcte_pkg::S_IDLE;
        endcase
    end

    // Output register.
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && !m_axis_tready;
        if (out_load) begin
            n_out       = out_load_data;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tcte_pkg::S_IDLE;
            r_now        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_nres       <= '0;
            r_free_found <= 1'b0;
            r_idx        <= '0;
            for (int i = 0; i < NUM_CONNS; i++) begin
                r_cst[i] <= tcte_pkg::CS_CLOSED;
            end
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_nres       <= n_nres;
            r_free_found <= n_free_found;
            r_idx        <= n_idx;
            if (in_acc && s_axis_tuser[0]) begin
                r_now <= r_now + 32'd1;
            end
            if (cst_we) begin
                r_cst[cst_addr] <= cst_val;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_free_idx <= n_free_idx;
        r_pend     <= n_pend;
        r_out      <= n_out;
        if (in_acc) begin
            r_op <= s_axis_tuser[0];
            r_in <= {s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[79:64],
                     s_axis_tdata[95:80], s_axis_tdata[96], s_axis_tdata[97],
                     s_axis_tdata[129:98], s_axis_tdata[161:130], s_axis_tdata[177:162]};
        end
    end

    `ASSERT_IMPL(a_idle_no_pend, i_clk, i_rst_n, r_state == tcte_pkg::S_IDLE, !r_pend_valid)
    `ASSERT_IMPL(a_nres_bound, i_clk, i_rst_n, 1'b1, r_nres <= 4'd8)
    `ASSERT_IMPL(a_synack_last, i_clk, i_rst_n,
                 r_out_valid && r_out.action == tcte_pkg::ACT_SYNACK, r_out.last && r_out.syn)
    `ASSERT_NEXT(a_flush_done, i_clk, i_rst_n,
                 r_state == tcte_pkg::S_FLUSH && out_free, r_state == tcte_pkg::S_IDLE)
endmodule
`default_nettype wire

// File: rtl/tcte_ram.sv
// Entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tcte_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire                   i_clk,
    input  wire                   i_we,
    input  wire [AW-1:0]          i_waddr,
    input  wire tcte_pkg::t_entry i_wdata,
    input  wire [AW-1:0]          i_raddr,
    output tcte_pkg::t_entry      o_rdata
);
    tcte_pkg::t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
